@@ design/mip_pkg.sv @@
// Shared constants for the power-of-two modular inverse block.
package mip_pkg;

  localparam int WORD_BITS = 64;
  localparam int IN_W      = 64;
  localparam int EXP_W     = 7;
  localparam int IDX_W     = $clog2(WORD_BITS);
  localparam int CNT_W     = $clog2(WORD_BITS + 1);

  localparam logic [EXP_W-1:0] EXP_MIN = EXP_W'(1);
  localparam logic [EXP_W-1:0] EXP_MAX = EXP_W'(WORD_BITS);

  typedef logic [WORD_BITS-1:0] word_t;

endpackage

@@ design/modular_inverse_pow2_top.sv @@
// Multiplicative inverse modulo 2^k, one result bit per cycle.
//
// Usage:
//   The input channel (in_valid, in_stall, in_value, in_exponent) takes a
//   value and an exponent k. The result channel (out_valid, out_stall,
//   out_inverse_value, out_invertible) returns one word per input word:
//   the x in 0 .. 2^k-1 with value * x = 1 mod 2^k, or 0 with
//   out_invertible low when the value is even. Exponent 0 counts as 1,
//   exponents above the word width count as the word width.
//   One subtract-and-shift step in a single shared adder settles one bit of
//   the inverse per cycle, so an item occupies the block until its result
//   is written to the output register, and in_stall stays high meanwhile.
//   The next item is accepted on the cycle after the result lands in the
//   output register, even if that
//   result is still waiting. If the receiver stalls while a result waits,
//   a finished computation holds until the output register frees up.
//   Reset (synchronous, active low) drops any item in flight and empties
//   the output register.
module modular_inverse_pow2_top (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        in_valid,
  output logic                        in_stall,
  input  logic [mip_pkg::IN_W-1:0]    in_value,
  input  logic [mip_pkg::EXP_W-1:0]   in_exponent,
  output logic                        out_valid,
  input  logic                        out_stall,
  output logic [mip_pkg::IN_W-1:0]    out_inverse_value,
  output logic                        out_invertible
);

  logic                        busy_r, busy_nxt;
  logic                        out_valid_r, out_valid_nxt;
  logic [mip_pkg::CNT_W-1:0]   cnt_r, cnt_nxt;
  logic [mip_pkg::IDX_W-1:0]   idx_r, idx_nxt;
  mip_pkg::word_t              v_r, v_nxt;
  mip_pkg::word_t              b_r, b_nxt;
  mip_pkg::word_t              x_r, x_nxt;
  logic [mip_pkg::IN_W-1:0]    res_r, res_nxt;
  logic                        inv_r, inv_nxt;

  logic [mip_pkg::EXP_W-1:0]   k_sat;
  mip_pkg::word_t              diff;
  logic                        accept;
  logic                        out_free;

  assign in_stall          = busy_r;
  assign accept            = in_valid && !busy_r;
  assign out_free          = !out_valid_r || !out_stall;
  assign out_valid         = out_valid_r;
  assign out_inverse_value = res_r;
  assign out_invertible    = inv_r;

  always_comb begin
    if (in_exponent < mip_pkg::EXP_MIN) begin
      k_sat = mip_pkg::EXP_MIN;
    end else if (in_exponent > mip_pkg::EXP_MAX) begin
      k_sat = mip_pkg::EXP_MAX;
    end else begin
      k_sat = in_exponent;
    end
  end

  // the shared unit: remainder minus value
  assign diff = b_r - v_r;

  always_comb begin
    busy_nxt      = busy_r;
    out_valid_nxt = out_valid_r;
    cnt_nxt       = cnt_r;
    idx_nxt       = idx_r;
    v_nxt         = v_r;
    b_nxt         = b_r;
    x_nxt         = x_r;
    res_nxt       = res_r;
    inv_nxt       = inv_r;

    if (out_valid_r && !out_stall) begin
      out_valid_nxt = 1'b0;
    end

    if (accept) begin
      busy_nxt = 1'b1;
      cnt_nxt  = mip_pkg::CNT_W'(k_sat);
      idx_nxt  = '0;
      v_nxt    = in_value[mip_pkg::WORD_BITS-1:0];
      b_nxt    = mip_pkg::word_t'(1);
      x_nxt    = '0;
    end else if (busy_r) begin
      if (cnt_r != '0) begin
        // keep v*x + 2^i*b = 1; set bit i when the remainder is odd
        if (b_r[0]) begin
          x_nxt[idx_r] = 1'b1;
          b_nxt        = diff >> 1;
        end else begin
          b_nxt = b_r >> 1;
        end
        idx_nxt = idx_r + 1'b1;
        cnt_nxt = cnt_r - 1'b1;
      end else if (out_free) begin
        busy_nxt      = 1'b0;
        out_valid_nxt = 1'b1;
        inv_nxt       = v_r[0];
        res_nxt       = v_r[0] ? mip_pkg::IN_W'(x_r) : '0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r      <= 1'b0;
      out_valid_r <= 1'b0;
      cnt_r       <= '0;
      idx_r       <= '0;
    end else begin
      busy_r      <= busy_nxt;
      out_valid_r <= out_valid_nxt;
      cnt_r       <= cnt_nxt;
      idx_r       <= idx_nxt;
    end
  end

  always_ff @(posedge clk) begin
    v_r   <= v_nxt;
    b_r   <= b_nxt;
    x_r   <= x_nxt;
    res_r <= res_nxt;
    inv_r <= inv_nxt;
  end

endmodule

@@ design/mip_checker.sv @@
// Port-level checks for the power-of-two modular inverse block, bound to the top level.
module mip_checker (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        in_valid,
  input  logic                        in_stall,
  input  logic [mip_pkg::IN_W-1:0]    in_value,
  input  logic [mip_pkg::EXP_W-1:0]   in_exponent,
  input  logic                        out_valid,
  input  logic                        out_stall,
  input  logic [mip_pkg::IN_W-1:0]    out_inverse_value,
  input  logic                        out_invertible
);

  // hold a stalled result word
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_inverse_value)
      && $stable(out_invertible))
    else $error("stalled result word changed or dropped");

  // an accepted word keeps the block busy on the next cycle
  a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && !in_stall |=> in_stall)
    else $error("block not busy after accepting a word");

  // no inverse means a zero result
  a_zero_when_even: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_invertible |-> out_inverse_value == '0)
    else $error("nonzero result without inverse");

  // an inverse of an odd number is odd
  a_odd_inverse: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_invertible |-> out_inverse_value[0])
    else $error("even inverse reported");

endmodule

bind modular_inverse_pow2_top mip_checker u_mip_checker (.*);
